@@ sv/cbst_pkg.sv @@
package cbst_pkg;

	localparam int BUCKETS     = 256;
	localparam int BKT_W       = 8;
	localparam int WAYS_DEF    = 4;
	localparam int RADIOS_DEF  = 3;
	localparam int NSLOT       = 3;

	typedef enum logic [3:0] {
		OP_ADD_STEER   = 4'd0,
		OP_ADD_BALANCE = 4'd1,
		OP_DEL_STEER   = 4'd2,
		OP_DEL_BALANCE = 4'd3,
		OP_CHECK       = 4'd4,
		OP_FLAG_TEST   = 4'd5,
		OP_FLAG_SET    = 4'd6,
		OP_FLAG_CLEAR  = 4'd7,
		OP_GET_CLIENT  = 4'd8,
		OP_FLUSH       = 4'd9
	} op_t;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STS_FULL      = 2'd2;

	localparam logic [1:0] RSN_NONE    = 2'd0;
	localparam logic [1:0] RSN_BALANCE = 2'd1;
	localparam logic [1:0] RSN_STEER   = 2'd2;

	typedef struct packed {
		logic                 vld;
		logic [47:0]          key;
		logic [7:0]           deny;
		logic [NSLOT-1:0]     occ;
		logic [2*NSLOT-1:0]   rid;
		logic [8*NSLOT-1:0]   chan;
		logic [8*NSLOT-1:0]   flg;
	} entry_t;

	localparam int ENT_W = $bits(entry_t);

	function automatic logic [BKT_W-1:0] bucket_of(input logic [47:0] mac);
		logic [BKT_W-1:0] h;
		h = '0;
		for (int b = 0; b < 6; b++) begin
			h = h ^ mac[8*b +: 8];
		end
		return h;
	endfunction

endpackage

@@ sv/client_band_steer_table.sv @@
// Channel | Direction | Signals
// in      | input     | in_valid / in_ready, op .. ssid_one_band
// out     | output    | out_valid / out_ready, status .. slot2_flags
//
// For each item the bucket row is read from the entry RAM in the accept cycle and
// modified and written back in the execute state once the output is free.
// After reset, and for every flush, a clearing pass writes all 256 bucket rows
// during which no item is accepted.
// A result held by a stalled output keeps the block in its write-back cycle.
module client_band_steer_table #(
	parameter int WAYS   = cbst_pkg::WAYS_DEF,
	parameter int RADIOS = cbst_pkg::RADIOS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  op,
	input  logic [47:0] station_mac,
	input  logic [1:0]  radio,
	input  logic [7:0]  channel,
	input  logic [7:0]  deny_count_in,
	input  logic [7:0]  flag_mask,
	input  logic        wps_active,
	input  logic        ssid_one_band,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        answer,
	output logic [1:0]  refuse_reason,
	output logic [7:0]  deny_count_out,
	output logic [2:0]  occupied_mask,
	output logic [7:0]  slot0_channel,
	output logic [7:0]  slot1_channel,
	output logic [7:0]  slot2_channel,
	output logic [7:0]  slot0_flags,
	output logic [7:0]  slot1_flags,
	output logic [7:0]  slot2_flags
);
	import cbst_pkg::*;

	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ROW_W = WAYS * ENT_W;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t state_q;
	logic [BKT_W-1:0] clr_q;
	logic             flush_pend_q;

	logic [3:0]       op_q;
	logic [47:0]      mac_q;
	logic [1:0]       radio_q;
	logic [7:0]       chan_q;
	logic [7:0]       deny_q;
	logic [7:0]       mask_q;
	logic             wps_q;
	logic             oneband_q;
	logic [BKT_W-1:0] bkt_q;

	logic             out_valid_q;
	logic [1:0]       status_q;
	logic             answer_q;
	logic [1:0]       reason_q;
	entry_t           show_q;

	entry_t [WAYS-1:0] rows;
	entry_t [WAYS-1:0] rows_wr;
	logic [ROW_W-1:0]  rdata;

	logic             accept;
	logic             out_free;
	logic             leave_exec;
	logic             ram_we;
	logic [BKT_W-1:0] ram_waddr;
	logic [ROW_W-1:0] ram_wdata;

	assign rows     = rdata;
	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign leave_exec = (state_q == S_EXEC) && out_free;

	// Lookup and entry update on the row read back from the RAM.
	logic             hit, free_any, create, have, known, radio_ok;
	logic [WAY_W-1:0] hit_w, free_w, tgt_w;
	entry_t           cur, nxt;
	logic [NSLOT-1:0] match;
	logic             any_match, free_slot_any;
	logic [1:0]       fm, fs;
	logic [1:0]       sts, rsn;
	logic             ans;

	always_comb begin
		hit = 1'b0;
		hit_w = '0;
		free_any = 1'b0;
		free_w = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (rows[w].vld && rows[w].key == mac_q) begin
				hit = 1'b1;
				hit_w = WAY_W'(w);
			end
			if (!rows[w].vld) begin
				free_any = 1'b1;
				free_w = WAY_W'(w);
			end
		end
		cur = hit ? rows[hit_w] : '0;
		radio_ok = ({1'b0, radio_q} < 3'(RADIOS));
		any_match = 1'b0;
		fm = '0;
		free_slot_any = 1'b0;
		fs = '0;
		for (int s = NSLOT - 1; s >= 0; s--) begin
			match[s] = radio_ok && cur.occ[s] && (cur.rid[2*s +: 2] == radio_q);
			if (match[s]) begin
				any_match = 1'b1;
				fm = 2'(s);
			end
			if (!cur.occ[s]) begin
				free_slot_any = 1'b1;
				fs = 2'(s);
			end
		end

		nxt = cur;
		sts = STS_OK;
		rsn = RSN_NONE;
		ans = 1'b0;
		create = 1'b0;
		known = 1'b1;
		case (op_q)
			OP_ADD_STEER: begin
				if (!radio_ok) begin
					sts = STS_NOT_FOUND;
				end else if (hit) begin
					if (!any_match && free_slot_any) begin
						for (int s = 0; s < NSLOT; s++) begin
							if (2'(s) == fs) begin
								nxt.occ[s] = 1'b1;
								nxt.rid[2*s +: 2] = radio_q;
								nxt.chan[8*s +: 8] = chan_q;
							end
						end
					end
				end else if (free_any) begin
					create = 1'b1;
					nxt = '0;
					nxt.vld = 1'b1;
					nxt.key = mac_q;
					nxt.occ[0] = 1'b1;
					nxt.rid[1:0] = radio_q;
					nxt.chan[7:0] = chan_q;
				end else begin
					sts = STS_FULL;
				end
			end
			OP_ADD_BALANCE: begin
				if (hit) begin
					nxt.deny = deny_q;
				end else if (free_any) begin
					create = 1'b1;
					nxt = '0;
					nxt.vld = 1'b1;
					nxt.key = mac_q;
					nxt.deny = deny_q;
				end else begin
					sts = STS_FULL;
				end
			end
			OP_DEL_STEER, OP_DEL_BALANCE: begin
				if (!hit) begin
					sts = STS_NOT_FOUND;
				end else begin
					if (op_q == OP_DEL_STEER) begin
						for (int s = 0; s < NSLOT; s++) begin
							if (match[s]) begin
								nxt.occ[s] = 1'b0;
								nxt.chan[8*s +: 8] = 8'd0;
							end
						end
					end else begin
						nxt.deny = 8'd0;
					end
					if (nxt.occ == '0 && nxt.deny == 8'd0) begin
						nxt.vld = 1'b0;
					end
				end
			end
			OP_CHECK: begin
				if (!hit) begin
					sts = STS_NOT_FOUND;
				end
				if (wps_q || !hit) begin
					ans = 1'b1;
				end else if (cur.deny != 8'd0) begin
					nxt.deny = cur.deny - 8'd1;
					rsn = RSN_BALANCE;
				end else if (any_match && !oneband_q) begin
					rsn = RSN_STEER;
				end else begin
					ans = 1'b1;
				end
			end
			OP_FLAG_TEST: begin
				if (!hit) begin
					sts = STS_NOT_FOUND;
				end
				for (int s = 0; s < NSLOT; s++) begin
					if (match[s] && ((cur.flg[8*s +: 8] & mask_q) == mask_q)) begin
						ans = 1'b1;
					end
				end
			end
			OP_FLAG_SET, OP_FLAG_CLEAR: begin
				if (!hit || !any_match) begin
					sts = STS_NOT_FOUND;
				end else begin
					for (int s = 0; s < NSLOT; s++) begin
						if (2'(s) == fm) begin
							if (op_q == OP_FLAG_SET) begin
								nxt.flg[8*s +: 8] = cur.flg[8*s +: 8] | mask_q;
							end else begin
								nxt.flg[8*s +: 8] = cur.flg[8*s +: 8] & ~mask_q;
							end
						end
					end
				end
			end
			OP_GET_CLIENT: begin
				if (!hit) begin
					sts = STS_NOT_FOUND;
				end
			end
			default: begin
				// Flush and undefined codes leave the row alone and show nothing.
				known = 1'b0;
			end
		endcase

		have = known && (hit || create);
		tgt_w = hit ? hit_w : free_w;
		rows_wr = rows;
		rows_wr[tgt_w] = nxt;
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we = leave_exec && have;
			ram_waddr = bkt_q;
			ram_wdata = rows_wr;
		end
	end

	cbst_ram #(
		.W (ROW_W),
		.D (BUCKETS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (bucket_of(station_mac)),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			flush_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (leave_exec) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + BKT_W'(1);
					if (clr_q == BKT_W'(BUCKETS - 1)) begin
						state_q <= flush_pend_q ? S_EXEC : S_IDLE;
						flush_pend_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (op == OP_FLUSH) begin
							state_q <= S_CLEAR;
							clr_q <= '0;
							flush_pend_q <= 1'b1;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
			mac_q <= station_mac;
			radio_q <= radio;
			chan_q <= channel;
			deny_q <= deny_count_in;
			mask_q <= flag_mask;
			wps_q <= wps_active;
			oneband_q <= ssid_one_band;
			bkt_q <= bucket_of(station_mac);
		end
		if (leave_exec) begin
			status_q <= sts;
			answer_q <= ans;
			reason_q <= rsn;
			show_q <= (have && nxt.vld) ? nxt : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign answer         = answer_q;
	assign refuse_reason  = reason_q;
	assign deny_count_out = show_q.deny;
	assign occupied_mask  = show_q.occ;
	assign slot0_channel  = show_q.chan[7:0];
	assign slot1_channel  = show_q.chan[15:8];
	assign slot2_channel  = show_q.chan[23:16];
	assign slot0_flags    = show_q.flg[7:0];
	assign slot1_flags    = show_q.flg[15:8];
	assign slot2_flags    = show_q.flg[23:16];
endmodule

@@ sv/cbst_ram.sv @@
module cbst_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ sv/cbst_checker.sv @@
module cbst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic        answer,
	input logic [1:0]  refuse_reason,
	input logic [7:0]  deny_count_out,
	input logic [2:0]  occupied_mask
);
	import cbst_pkg::*;

	// A beat is worked on one at a time, so ready drops right after an accept.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in flight");

	a_refuse_denies: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && refuse_reason != RSN_NONE |-> !answer)
		else $error("refusal with allow answer");

	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STS_FULL |-> deny_count_out == 8'd0 && occupied_mask == 3'd0)
		else $error("table full result shows an entry");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("stalled result changed");
endmodule

bind client_band_steer_table cbst_checker u_cbst_checker (.*);
